FILE: src/qpsk_pll_pkg.sv
// Package: shared types, constants and the arctangent table of the QPSK phase-locked loop.
package qpsk_pll_pkg;

  // Sample and datapath widths
  localparam int unsigned SampleW   = 16;
  localparam int unsigned GuardW    = 8;
  localparam int unsigned CordicW   = SampleW + GuardW + 4;
  localparam int unsigned AngleW    = 34;
  localparam int unsigned ErrW      = 32;
  localparam int unsigned PhaseW    = 16;
  localparam int unsigned GainW     = 16;
  localparam int unsigned MulAW     = 32;
  localparam int unsigned MulBW     = 17;
  localparam int unsigned ProdW     = MulAW + MulBW;

  // Iterations per pass and table depth
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned AtanDepth   = 24;
  localparam int unsigned StepW       = $clog2(AtanDepth);

  // 1/K in Q0.16 and reset loop gain (about 0.002)
  localparam logic [MulBW-1:0] InvGain   = 17'd39797;
  localparam logic [GainW-1:0] GainReset = 16'd131;

  typedef enum logic [2:0] {
    StIdle,
    StRot,
    StSclI,
    StSclQ,
    StVecLd,
    StVec,
    StErr,
    StDone
  } state_e;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turns(input logic [StepW-1:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

FILE: src/qpsk_decision_directed_pll.sv
// Top level: QPSK decision-directed first-order phase-locked loop on one shared CORDIC unit.
//
// Use of the block:
//   s_axis: one input word per sample; tdata = {sample_q, sample_i} (sample_i in the
//   low 16 bits), tlast marks the last sample of a burst.
//   m_axis: one output word per sample; tdata = {out_q, out_i}, tlast copies the
//   input tlast.
//   cfg: write loop_gain (unsigned Q0.16) on cfg_valid_i; cfg_ready_o is always high.
//   Write it only while the loop is idle.
// Processing: a sample goes from acceptance to the output register through two passes of
//   16 iterations through the single CORDIC step unit plus the shared multiplier used
//   for the two gain corrections and the loop update. s_axis_tready is high only in
//   the idle state, so a new sample is taken only after the last one has finished.
// Stalls: the result sits in an output register; the next sample is accepted and
//   processed while it waits, and the loop holds in its final step until that
//   register is free, so no result is lost.
// Reset: phase estimate returns to zero (unit phasor), loop_gain to 131, the
//   output register empties. After a sample with tlast set the phase returns to zero.
module qpsk_decision_directed_pll (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input samples
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] sample_i, [31:16] sample_q
  input  logic        s_axis_tlast,   // last_in_burst
  // Corrected samples
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] out_i, [31:16] out_q
  output logic        m_axis_tlast,   // out_last
  // Loop gain register
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i      // loop_gain
);

  localparam int unsigned SW  = qpsk_pll_pkg::SampleW;
  localparam int unsigned CW  = qpsk_pll_pkg::CordicW;
  localparam int unsigned ZW  = qpsk_pll_pkg::AngleW;
  localparam int unsigned PW  = qpsk_pll_pkg::ProdW;
  localparam int unsigned GW  = qpsk_pll_pkg::GuardW;
  localparam int unsigned STW = qpsk_pll_pkg::StepW;
  localparam int unsigned AW  = qpsk_pll_pkg::MulAW;
  localparam int unsigned ErrW_L = qpsk_pll_pkg::ErrW;

  qpsk_pll_pkg::state_e state_q, state_d;

  // Working registers of the shared unit
  logic signed [CW-1:0] x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic [STW-1:0]       step_q, step_d;
  logic signed [PW-1:0] mul_q, mul_d;
  logic signed [SW-1:0] yi_q, yi_d, yq_q, yq_d;
  logic                 last_q, last_d;
  logic [qpsk_pll_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [qpsk_pll_pkg::GainW-1:0]  gain_q;

  // Output register
  logic          m_valid_q, m_valid_d;
  logic [31:0]   m_data_q, m_data_d;
  logic          m_last_q, m_last_d;

  // Control decoded from the state
  logic accept, steps_done, out_load;

  // Shared step unit, multiplier and helpers
  logic signed [CW-1:0]    dx, dy, x_step, y_step;
  logic signed [ZW-1:0]    z_step, atan_z;
  logic                    ccw;
  logic signed [AW-1:0]    mul_a;
  logic signed [qpsk_pll_pkg::MulBW-1:0] mul_b;
  logic signed [PW-1:0]    prod;
  logic signed [SW-1:0]    scaled;
  logic signed [ErrW_L-1:0] err;
  logic signed [ZW-1:0]    dec, diff;
  logic [qpsk_pll_pkg::PhaseW-1:0] ph_adj, res, delta;
  logic [1:0]              quad;
  logic signed [CW-1:0]    xs, ys, xv, yv;

  // Saturate a rounded product shifted down by 24 to the sample range
  function automatic logic signed [SW-1:0] sat_scale(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] r;
    logic signed [PW-25:0] s;
    logic signed [SW-1:0] o;
    r = p + (PW'(1) <<< 23);
    s = r[PW-1:24];
    if (s > (PW-24)'((1 << (SW - 1)) - 1)) begin
      o = {1'b0, {(SW - 1){1'b1}}};
    end else if (s < -(PW-24)'(1 << (SW - 1))) begin
      o = {1'b1, {(SW - 1){1'b0}}};
    end else begin
      o = s[SW-1:0];
    end
    return o;
  endfunction

  assign accept      = (state_q == qpsk_pll_pkg::StIdle) && s_axis_tvalid;
  assign steps_done  = (step_q == STW'(qpsk_pll_pkg::CordicSteps - 1));
  assign cfg_ready_o = 1'b1;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      qpsk_pll_pkg::StIdle:  if (s_axis_tvalid) state_d = qpsk_pll_pkg::StRot;
      qpsk_pll_pkg::StRot:   if (steps_done) state_d = qpsk_pll_pkg::StSclI;
      qpsk_pll_pkg::StSclI:  state_d = qpsk_pll_pkg::StSclQ;
      qpsk_pll_pkg::StSclQ:  state_d = qpsk_pll_pkg::StVecLd;
      qpsk_pll_pkg::StVecLd: state_d = qpsk_pll_pkg::StVec;
      qpsk_pll_pkg::StVec:   if (steps_done) state_d = qpsk_pll_pkg::StErr;
      qpsk_pll_pkg::StErr:   state_d = qpsk_pll_pkg::StDone;
      qpsk_pll_pkg::StDone:  if (!m_valid_q || m_axis_tready) state_d = qpsk_pll_pkg::StIdle;
      default:               state_d = qpsk_pll_pkg::StIdle;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      qpsk_pll_pkg::StIdle: s_axis_tready = 1'b1;
      qpsk_pll_pkg::StDone: out_load = !m_valid_q || m_axis_tready;
      default: begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
      end
    endcase
  end

  // Shared CORDIC step: rotation steers on z, vectoring drives y to zero
  always_comb begin
    dx     = y_q >>> step_q;
    dy     = x_q >>> step_q;
    ccw    = (state_q == qpsk_pll_pkg::StRot) ? !z_q[ZW-1] : y_q[CW-1];
    atan_z = signed'(ZW'(qpsk_pll_pkg::atan_turns(step_q)));
    if (ccw) begin
      x_step = x_q - dx;
      y_step = y_q + dy;
      z_step = z_q - atan_z;
    end else begin
      x_step = x_q + dx;
      y_step = y_q - dy;
      z_step = z_q + atan_z;
    end
  end

  // Shared multiplier operands: 1/K correction of x, then y, then the loop gain
  always_comb begin
    mul_a = AW'(x_q);
    mul_b = signed'(qpsk_pll_pkg::InvGain);
    case (state_q)
      qpsk_pll_pkg::StSclQ: mul_a = AW'(y_q);
      qpsk_pll_pkg::StErr: begin
        mul_a = err;
        mul_b = signed'({1'b0, gain_q});
      end
      default: mul_a = AW'(x_q);
    endcase
    prod   = PW'(mul_a) * PW'(mul_b);
    scaled = sat_scale(mul_q);
  end

  // Phase error against the decided quadrant point, wrapped to 32 bits
  always_comb begin
    if (!yi_q[SW-1] && !yq_q[SW-1]) begin
      dec = ZW'(32'sh2000_0000);
    end else if (!yi_q[SW-1]) begin
      dec = -ZW'(32'sh2000_0000);
    end else if (yq_q[SW-1]) begin
      dec = -ZW'(32'sh6000_0000);
    end else begin
      dec = ZW'(32'sh6000_0000);
    end
    diff = z_q - dec;
    if (yi_q == '0 && yq_q == '0) begin
      err = '0;
    end else begin
      err = diff[ErrW_L-1:0];
    end
  end

  // Datapath next values
  always_comb begin
    x_d      = x_q;
    y_d      = y_q;
    z_d      = z_q;
    step_d   = step_q;
    mul_d    = mul_q;
    yi_d     = yi_q;
    yq_d     = yq_q;
    last_d   = last_q;
    phase_d  = phase_q;
    m_data_d = m_data_q;
    m_last_d = m_last_q;

    // Quarter-turn split of the phase estimate
    ph_adj = phase_q + 16'h2000;
    quad   = ph_adj[15:14];
    res    = phase_q - {quad, 14'b0};
    xs     = {{(CW - SW - GW){s_axis_tdata[SW-1]}}, s_axis_tdata[SW-1:0], {GW{1'b0}}};
    ys     = {{(CW - SW - GW){s_axis_tdata[2*SW-1]}}, s_axis_tdata[2*SW-1:SW], {GW{1'b0}}};
    xv     = {{(CW - SW - GW){yi_q[SW-1]}}, yi_q, {GW{1'b0}}};
    yv     = {{(CW - SW - GW){yq_q[SW-1]}}, yq_q, {GW{1'b0}}};
    delta  = qpsk_pll_pkg::PhaseW'((mul_q + (PW'(1) <<< 31)) >>> 32);

    case (state_q)
      qpsk_pll_pkg::StIdle: begin
        if (accept) begin
          last_d = s_axis_tlast;
          step_d = '0;
          z_d    = {{(ZW - 32){res[15]}}, res, 16'b0};
          case (quad)
            2'd0: begin x_d = xs;  y_d = ys;  end
            2'd1: begin x_d = -ys; y_d = xs;  end
            2'd2: begin x_d = -xs; y_d = -ys; end
            default: begin x_d = ys; y_d = -xs; end
          endcase
        end
      end
      qpsk_pll_pkg::StRot, qpsk_pll_pkg::StVec: begin
        x_d    = x_step;
        y_d    = y_step;
        z_d    = z_step;
        step_d = steps_done ? '0 : step_q + 1'b1;
      end
      qpsk_pll_pkg::StSclI: mul_d = prod;
      qpsk_pll_pkg::StSclQ: begin
        yi_d  = scaled;
        mul_d = prod;
      end
      qpsk_pll_pkg::StVecLd: begin
        yq_d   = scaled;
        step_d = '0;
        // Vector the saturated output; use the freshly scaled q part
        xv = {{(CW - SW - GW){yi_q[SW-1]}}, yi_q, {GW{1'b0}}};
        yv = {{(CW - SW - GW){scaled[SW-1]}}, scaled, {GW{1'b0}}};
        if (xv[CW-1]) begin
          if (!yv[CW-1]) begin
            x_d = yv;
            y_d = -xv;
            z_d = ZW'(32'sh4000_0000);
          end else begin
            x_d = -yv;
            y_d = xv;
            z_d = -ZW'(32'sh4000_0000);
          end
        end else begin
          x_d = xv;
          y_d = yv;
          z_d = '0;
        end
      end
      qpsk_pll_pkg::StErr: mul_d = prod;
      qpsk_pll_pkg::StDone: begin
        if (out_load) begin
          m_data_d = {yq_q, yi_q};
          m_last_d = last_q;
          phase_d  = last_q ? '0 : phase_q - delta;
        end
      end
      default: begin
        x_d = x_q;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  // Control state and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= qpsk_pll_pkg::StIdle;
      step_q    <= '0;
      phase_q   <= '0;
      gain_q    <= qpsk_pll_pkg::GainReset;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      phase_q   <= phase_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i) begin
        gain_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    y_q      <= y_d;
    z_q      <= z_d;
    mul_q    <= mul_d;
    yi_q     <= yi_d;
    yq_q     <= yq_d;
    last_q   <= last_d;
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule
